/* sv/weighted_pixel_prediction_defines.svh */
// assertion macros for the weighted pixel prediction port checker
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef WEIGHTED_PIXEL_PREDICTION_DEFINES_SVH
`define WEIGHTED_PIXEL_PREDICTION_DEFINES_SVH

// generic clocked check, off while reset is asserted
`define WPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// a stalled transfer keeps the given signal unchanged on the next cycle
`define WPP_ASSERT_HOLD(label, vld, rdy, sig, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (vld && !rdy) |=> $stable(sig)) else $error(msg);

`endif

/* sv/wpp_pkg.sv */
// shared types and constants for the weighted pixel prediction block
// no dependencies
package wpp_pkg;

    // pixel packing
    localparam int PIX_W     = 8;
    localparam int ROW_W     = 64;
    localparam int PIX_LANES = ROW_W / PIX_W;
    localparam int LANES     = 8;
    localparam int LANE_CNT  = (LANES < PIX_LANES) ? LANES : PIX_LANES;

    // configuration port
    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = $clog2(REG_COUNT);
    localparam int ADDR_W    = REG_IDX_W + 2;

    // field widths
    localparam int ACTION_W = 2;
    localparam int WEIGHT_W = 8;
    localparam int ROUND_W  = 9;
    localparam int SHIFT_W  = 4;
    localparam int OFFSET_W = 8;

    // reset values of the configuration registers
    localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(1);
    localparam logic [ROUND_W-1:0]  ROUND_RST  = '0;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST  = '0;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_AVG    = 2'd0,
        ACT_SINGLE = 2'd1,
        ACT_BI     = 2'd2
    } t_action;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_WEIGHT_FIRST      = 3'd0,
        REG_WEIGHT_SECOND     = 3'd1,
        REG_WEIGHT_FIRST_ALT  = 3'd2,
        REG_WEIGHT_SECOND_ALT = 3'd3,
        REG_ROUND_ADD         = 3'd4,
        REG_SHIFT_AMOUNT      = 3'd5,
        REG_OFFSET_MAIN       = 3'd6,
        REG_OFFSET_ALT        = 3'd7
    } t_reg_idx;

endpackage

/* sv/wpp_in_if.sv */
// input channel: one row group of reference pixels per transfer
// depends on wpp_pkg
interface wpp_in_if;
    import wpp_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic                interleaved_uv;
    logic [ROW_W-1:0]    pixels_a;
    logic [ROW_W-1:0]    pixels_b;

    modport source (output valid, action, interleaved_uv, pixels_a, pixels_b, input ready);
    modport sink   (input valid, action, interleaved_uv, pixels_a, pixels_b, output ready);
endinterface

/* sv/wpp_out_if.sv */
// output channel: one row group of predicted pixels per transfer
// depends on wpp_pkg
interface wpp_out_if;
    import wpp_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] pixels_out;

    modport source (output valid, pixels_out, input ready);
    modport sink   (input valid, pixels_out, output ready);
endinterface

/* sv/weighted_pixel_prediction.sv */
// top level of the weighted pixel prediction block
// depends on wpp_pkg, wpp_in_if and wpp_out_if
//
// usage
//   i_pix carries one row group per transfer: the action code, the
//   interleaved chroma flag and eight 8-bit pixels of each reference.
//   o_pred returns the eight predicted pixels of that row, in order.
//   the user writes weights, rounding, shift and offsets over the APB port
//   while no row is in flight (unenforced); reads return the stored values.
// timing
//   an input register and a result register around one pass of lane
//   arithmetic (a rounded average, or one 8x9 multiply per weight, add,
//   shift, offset, clip). the input transfer fills the input register and
//   the result register loads the lane result from it; one row is
//   accepted every cycle as long as o_pred.ready stays high.
// reset
//   synchronous, active low: both stages empty, registers back to unity
//   weights, zero rounding, zero shift and zero offsets.
// stalls
//   when o_pred.ready is low the result holds; the input register still
//   fills once more, after which i_pix.ready drops until the output moves.
module weighted_pixel_prediction (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wpp_in_if.sink                      i_pix,
    wpp_out_if.source                   o_pred,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wpp_pkg::ADDR_W-1:0]  paddr,
    input  logic [wpp_pkg::DATA_W-1:0]  pwdata,
    output logic [wpp_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import wpp_pkg::*;

    // configuration registers
    logic [WEIGHT_W-1:0] r_weight_first;
    logic [WEIGHT_W-1:0] r_weight_second;
    logic [WEIGHT_W-1:0] r_weight_first_alt;
    logic [WEIGHT_W-1:0] r_weight_second_alt;
    logic [ROUND_W-1:0]  r_round_add;
    logic [SHIFT_W-1:0]  r_shift_amount;
    logic [OFFSET_W-1:0] r_offset_main;
    logic [OFFSET_W-1:0] r_offset_alt;

    // input stage
    logic             r_s1_valid;
    t_action          r_action;
    logic             r_inter;
    logic [ROW_W-1:0] r_pix_a;
    logic [ROW_W-1:0] r_pix_b;

    // result stage
    logic             r_out_valid;
    logic [ROW_W-1:0] r_pixels_out;
    logic [ROW_W-1:0] n_pixels_out;

    logic     cfg_wr;
    t_reg_idx cfg_idx;
    logic     s1_adv;
    logic     in_xfer;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight_first      <= WEIGHT_RST;
            r_weight_second     <= WEIGHT_RST;
            r_weight_first_alt  <= WEIGHT_RST;
            r_weight_second_alt <= WEIGHT_RST;
            r_round_add         <= ROUND_RST;
            r_shift_amount      <= SHIFT_RST;
            r_offset_main       <= OFFSET_RST;
            r_offset_alt        <= OFFSET_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_WEIGHT_FIRST:      r_weight_first      <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_SECOND:     r_weight_second     <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_FIRST_ALT:  r_weight_first_alt  <= pwdata[WEIGHT_W-1:0];
                REG_WEIGHT_SECOND_ALT: r_weight_second_alt <= pwdata[WEIGHT_W-1:0];
                REG_ROUND_ADD:         r_round_add         <= pwdata[ROUND_W-1:0];
                REG_SHIFT_AMOUNT:      r_shift_amount      <= pwdata[SHIFT_W-1:0];
                REG_OFFSET_MAIN:       r_offset_main       <= pwdata[OFFSET_W-1:0];
                REG_OFFSET_ALT:        r_offset_alt        <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        case (cfg_idx)
            REG_WEIGHT_FIRST:      prdata = DATA_W'(r_weight_first);
            REG_WEIGHT_SECOND:     prdata = DATA_W'(r_weight_second);
            REG_WEIGHT_FIRST_ALT:  prdata = DATA_W'(r_weight_first_alt);
            REG_WEIGHT_SECOND_ALT: prdata = DATA_W'(r_weight_second_alt);
            REG_ROUND_ADD:         prdata = DATA_W'(r_round_add);
            REG_SHIFT_AMOUNT:      prdata = DATA_W'(r_shift_amount);
            REG_OFFSET_MAIN:       prdata = DATA_W'(r_offset_main);
            REG_OFFSET_ALT:        prdata = DATA_W'(r_offset_alt);
            default:               prdata = '0;
        endcase
    end

    // pipeline flow control
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_pred.ready);
    assign i_pix.ready = i_rst_n && (!r_s1_valid || s1_adv);
    assign in_xfer     = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_action <= t_action'(i_pix.action);
            r_inter  <= i_pix.interleaved_uv;
            r_pix_a  <= i_pix.pixels_a;
            r_pix_b  <= i_pix.pixels_b;
        end
    end

    // per-lane prediction; lanes are independent
    always_comb begin
        logic                         alt;
        logic [PIX_W:0]               avg;
        logic signed [PIX_W:0]        a_s;
        logic signed [PIX_W:0]        b_s;
        logic signed [WEIGHT_W-1:0]   w1;
        logic signed [WEIGHT_W-1:0]   w2;
        logic signed [OFFSET_W-1:0]   off;
        logic signed [16:0]           prod1;
        logic signed [16:0]           prod2;
        logic signed [17:0]           sum;
        logic signed [17:0]           shf;
        logic signed [18:0]           biased;
        logic [PIX_W-1:0]             clipped;
        n_pixels_out = '0;
        for (int lane = 0; lane < LANE_CNT; lane++) begin
            alt   = r_inter && (lane % 2 == 1);
            a_s   = $signed({1'b0, r_pix_a[lane*PIX_W +: PIX_W]});
            b_s   = $signed({1'b0, r_pix_b[lane*PIX_W +: PIX_W]});
            w1    = $signed(alt ? r_weight_first_alt  : r_weight_first);
            w2    = $signed(alt ? r_weight_second_alt : r_weight_second);
            off   = $signed(alt ? r_offset_alt : r_offset_main);
            avg   = {1'b0, r_pix_a[lane*PIX_W +: PIX_W]}
                  + {1'b0, r_pix_b[lane*PIX_W +: PIX_W]} + (PIX_W+1)'(1);
            prod1 = w1 * a_s;
            // signed zero keeps the second product a signed multiply
            prod2 = (r_action == ACT_BI) ? w2 * b_s : 17'sd0;
            sum   = 18'(prod1) + 18'(prod2) + $signed({9'b0, r_round_add});
            shf   = sum >>> r_shift_amount;
            biased = 19'(shf) + 19'(off);
            // clip to the pixel range
            if (biased < 0) begin
                clipped = '0;
            end else if (biased > 19'sd255) begin
                clipped = '1;
            end else begin
                clipped = biased[PIX_W-1:0];
            end
            case (r_action)
                ACT_AVG:    n_pixels_out[lane*PIX_W +: PIX_W] = avg[PIX_W:1];
                ACT_SINGLE: n_pixels_out[lane*PIX_W +: PIX_W] = clipped;
                ACT_BI:     n_pixels_out[lane*PIX_W +: PIX_W] = clipped;
                default:    n_pixels_out[lane*PIX_W +: PIX_W] = '0;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_pred.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_pixels_out <= n_pixels_out;
        end
    end

    assign o_pred.valid      = r_out_valid;
    assign o_pred.pixels_out = r_pixels_out;

endmodule

/* sv/wpp_checker.sv */
// port-level checks for the weighted pixel prediction block, bound to the top
// depends on weighted_pixel_prediction_defines.svh
`include "weighted_pixel_prediction_defines.svh"

module wpp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_pixels
);

    // a stalled result keeps its valid and its pixels
    `WPP_ASSERT(a_out_valid_hold, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")
    `WPP_ASSERT_HOLD(a_out_data_hold, i_out_valid, i_out_ready, i_out_pixels, "result changed while stalled")

    // an empty output side never blocks the input
    `WPP_ASSERT(a_in_ready_free, !i_out_valid |-> i_in_ready, "input blocked with empty output")

    // a fresh result comes from an earlier input transfer, through the input register
    `WPP_ASSERT(a_out_latency, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2), "result without matching input transfer")

endmodule

bind weighted_pixel_prediction wpp_checker u_wpp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_pix.valid),
    .i_in_ready   (i_pix.ready),
    .i_out_valid  (o_pred.valid),
    .i_out_ready  (o_pred.ready),
    .i_out_pixels (o_pred.pixels_out)
);

/* tb/sv/wpp_row_checker.sv */
// checker for the weighted pixel prediction block: mirrors the register writes,
// predicts every row group at its input transfer and compares it at the output
// depends on wpp_pkg, wpp_in_if and wpp_out_if
module wpp_row_checker
    import wpp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    wpp_in_if                   i_pix,
    wpp_out_if                  i_pred,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    input  logic                pready,
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_checked
);

    // mismatch lines beyond this count are only counted
    localparam int REPORT_MAX = 50;

    // own copy of the configuration registers
    logic [WEIGHT_W-1:0] wgt_first;
    logic [WEIGHT_W-1:0] wgt_second;
    logic [WEIGHT_W-1:0] wgt_first_alt;
    logic [WEIGHT_W-1:0] wgt_second_alt;
    logic [ROUND_W-1:0]  round_add;
    logic [SHIFT_W-1:0]  shift_amt;
    logic [OFFSET_W-1:0] ofs_main;
    logic [OFFSET_W-1:0] ofs_alt;

    logic [ROW_W-1:0] expected_rows [$];
    logic [ROW_W-1:0] exp_row;
    int               fail_cnt;
    int               check_cnt;

    // predicted row: per lane average or weighted sum, arithmetic shift, offset, clip
    function automatic logic [ROW_W-1:0] weighted_row(input logic [ACTION_W-1:0] act,
                                                      input logic inter,
                                                      input logic [ROW_W-1:0] ref_a,
                                                      input logic [ROW_W-1:0] ref_b);
        logic [ROW_W-1:0] row;
        longint           pa, pb, w1, w2, ofs, acc;
        logic             alt;
        int               lane;
        row = '0;
        for (lane = 0; lane < LANE_CNT; lane++) begin
            pa  = longint'(ref_a[PIX_W*lane +: PIX_W]);
            pb  = longint'(ref_b[PIX_W*lane +: PIX_W]);
            // odd lanes carry V when chroma is interleaved
            alt = inter && (lane % 2 == 1);
            w1  = longint'($signed(alt ? wgt_first_alt : wgt_first));
            w2  = longint'($signed(alt ? wgt_second_alt : wgt_second));
            ofs = longint'($signed(alt ? ofs_alt : ofs_main));
            case (act)
                ACT_AVG: begin
                    acc = (pa + pb + 1) >>> 1;
                end
                ACT_SINGLE: begin
                    acc = ((w1 * pa + longint'(round_add)) >>> shift_amt) + ofs;
                end
                ACT_BI: begin
                    acc = ((w1 * pa + w2 * pb + longint'(round_add)) >>> shift_amt) + ofs;
                end
                default: begin
                    acc = 0;
                end
            endcase
            if (acc < 0) begin
                acc = 0;
            end else if (acc > 255) begin
                acc = 255;
            end
            row[PIX_W*lane +: PIX_W] = PIX_W'(acc);
        end
        return row;
    endfunction

    // register writes, predictions at the input, comparison at the output
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wgt_first      <= WEIGHT_RST;
            wgt_second     <= WEIGHT_RST;
            wgt_first_alt  <= WEIGHT_RST;
            wgt_second_alt <= WEIGHT_RST;
            round_add      <= ROUND_RST;
            shift_amt      <= SHIFT_RST;
            ofs_main       <= OFFSET_RST;
            ofs_alt        <= OFFSET_RST;
            expected_rows.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_WEIGHT_FIRST:      wgt_first      <= pwdata[WEIGHT_W-1:0];
                    REG_WEIGHT_SECOND:     wgt_second     <= pwdata[WEIGHT_W-1:0];
                    REG_WEIGHT_FIRST_ALT:  wgt_first_alt  <= pwdata[WEIGHT_W-1:0];
                    REG_WEIGHT_SECOND_ALT: wgt_second_alt <= pwdata[WEIGHT_W-1:0];
                    REG_ROUND_ADD:         round_add      <= pwdata[ROUND_W-1:0];
                    REG_SHIFT_AMOUNT:      shift_amt      <= pwdata[SHIFT_W-1:0];
                    REG_OFFSET_MAIN:       ofs_main       <= pwdata[OFFSET_W-1:0];
                    REG_OFFSET_ALT:        ofs_alt        <= pwdata[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready) begin
                expected_rows.push_back(weighted_row(i_pix.action, i_pix.interleaved_uv,
                                                     i_pix.pixels_a, i_pix.pixels_b));
            end
            if (i_pred.valid && i_pred.ready) begin
                if (expected_rows.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX) begin
                        $display("%0t: unexpected result transfer, expected none, got %h",
                                 $time, i_pred.pixels_out);
                    end
                end else begin
                    exp_row = expected_rows.pop_front();
                    check_cnt++;
                    if (i_pred.pixels_out !== exp_row) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX) begin
                            $display("%0t: pixels_out mismatch, expected %h, got %h",
                                     $time, exp_row, i_pred.pixels_out);
                        end
                    end
                end
            end
        end
        o_errors  <= fail_cnt;
        o_pending <= expected_rows.size();
        o_checked <= check_cnt;
    end

endmodule

/* tb/sv/tb_weighted_pixel_prediction.sv */
// top of the weighted pixel prediction testbench: clock, reset, register setup,
// row stimulus with random gaps and output stalls, watchdog and verdict
// depends on wpp_pkg, wpp_in_if, wpp_out_if, wpp_row_checker and the block
module tb_weighted_pixel_prediction;
    import wpp_pkg::*;

    // action code outside the defined set, expected to give an all-zero row
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RAND_PHASES    = 8;
    localparam int ROWS_PER_PHASE = 225;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic              pready;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;

    wpp_in_if  pix_if ();
    wpp_out_if pred_if ();

    int errors;
    int pending;
    int checked;
    bit gaps_on;
    int stall_left;
    int idle_cycles;
    int rows_sent;
    int settings_applied;
    int inter_rows;
    int action_rows [4];

    weighted_pixel_prediction DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_pred  (pred_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wpp_row_checker row_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (pix_if),
        .i_pred    (pred_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // output back-pressure: mostly short stalls, a few long ones
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            pred_if.ready <= (stall_left == 1);
        end else if (gaps_on && $urandom_range(0, 99) < 25) begin
            stall_left    <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(8, 40);
            pred_if.ready <= 1'b0;
        end else begin
            pred_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (pred_if.valid && pred_if.ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // gap before an input transfer
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // row of pixels with the lane extremes well represented
    function automatic logic [ROW_W-1:0] pixel_row();
        logic [ROW_W-1:0] row;
        int               lane;
        for (lane = 0; lane < PIX_LANES; lane++) begin
            case ($urandom_range(0, 9))
                0:       row[PIX_W*lane +: PIX_W] = '0;
                1:       row[PIX_W*lane +: PIX_W] = '1;
                default: row[PIX_W*lane +: PIX_W] = PIX_W'($urandom_range(0, 255));
            endcase
        end
        return row;
    endfunction

    // one transfer on the input channel, after a random gap
    task automatic send_row(input logic [ACTION_W-1:0] act, input logic inter,
                            input logic [ROW_W-1:0] ref_a, input logic [ROW_W-1:0] ref_b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid          <= 1'b1;
        pix_if.action         <= act;
        pix_if.interleaved_uv <= inter;
        pix_if.pixels_a       <= ref_a;
        pix_if.pixels_b       <= ref_b;
        do @(posedge i_clk); while (!pix_if.ready);
        rows_sent++;
        action_rows[act]++;
        if (inter) begin
            inter_rows++;
        end
    endtask

    // stop sending and wait until every predicted row has come out
    task automatic drain_rows();
        pix_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write: setup cycle, then access cycle until pready
    task automatic apb_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // full register setting, only written with no row in flight
    task automatic set_config(input logic [WEIGHT_W-1:0] w1, input logic [WEIGHT_W-1:0] w2,
                              input logic [WEIGHT_W-1:0] w1a, input logic [WEIGHT_W-1:0] w2a,
                              input logic [ROUND_W-1:0] rnd, input logic [SHIFT_W-1:0] sh,
                              input logic [OFFSET_W-1:0] om, input logic [OFFSET_W-1:0] oa);
        drain_rows();
        apb_write(REG_WEIGHT_FIRST, DATA_W'(w1));
        apb_write(REG_WEIGHT_SECOND, DATA_W'(w2));
        apb_write(REG_WEIGHT_FIRST_ALT, DATA_W'(w1a));
        apb_write(REG_WEIGHT_SECOND_ALT, DATA_W'(w2a));
        apb_write(REG_ROUND_ADD, DATA_W'(rnd));
        apb_write(REG_SHIFT_AMOUNT, DATA_W'(sh));
        apb_write(REG_OFFSET_MAIN, DATA_W'(om));
        apb_write(REG_OFFSET_ALT, DATA_W'(oa));
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_applied++;
    endtask

    // stimulus and verdict
    initial begin
        logic [WEIGHT_W-1:0] wgt [4];
        logic [OFFSET_W-1:0] ofs_m;
        logic [OFFSET_W-1:0] ofs_a;
        logic [ACTION_W-1:0] act;
        int                  shift, rnd, r, phase, n, k;

        i_rst_n               <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        pix_if.valid          <= 1'b0;
        pix_if.action         <= ACT_AVG;
        pix_if.interleaved_uv <= 1'b0;
        pix_if.pixels_a       <= '0;
        pix_if.pixels_b       <= '0;
        gaps_on               <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gaps_on <= 1'b1;

        // reset setting: unity weights, no rounding, shift or offset
        send_row(ACT_AVG, 1'b0, '0, '0);
        send_row(ACT_AVG, 1'b0, '1, '1);
        send_row(ACT_AVG, 1'b0, '1, '0);
        send_row(ACT_AVG, 1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_row(ACT_SINGLE, 1'b0, '1, 64'h5a5a_a5a5_5a5a_a5a5);
        send_row(ACT_BI, 1'b0, '1, '1);
        send_row(ACT_RESERVED, 1'b0, '1, '1);

        // extreme weights of both signs, largest in-range rounding and shift
        set_config(8'h7f, 8'h80, 8'h80, 8'h7f, 9'd256, 4'd8, 8'h7f, 8'h80);
        send_row(ACT_SINGLE, 1'b1, '1, '0);
        send_row(ACT_BI, 1'b1, '1, '1);
        send_row(ACT_BI, 1'b0, '0, '1);
        send_row(ACT_BI, 1'b1, 64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00);

        // rounding and shift beyond their usual range
        set_config(8'h80, 8'h80, 8'h80, 8'h80, 9'h1ff, 4'hf, 8'h80, 8'h7f);
        send_row(ACT_SINGLE, 1'b1, '1, '1);
        send_row(ACT_BI, 1'b1, '1, '0);
        send_row(ACT_AVG, 1'b1, 64'h8000_ff01_7f80_00ff, 64'h0180_00fe_8081_ff00);
        send_row(ACT_RESERVED, 1'b1, '1, 64'h1234_5678_9abc_def0);

        // largest positive weights with no shift, saturation on both offsets
        set_config(8'h7f, 8'h7f, 8'h7f, 8'h7f, 9'd0, 4'd0, 8'h7f, 8'h80);
        send_row(ACT_BI, 1'b0, '1, '1);
        send_row(ACT_SINGLE, 1'b1, '0, '1);
        send_row(ACT_BI, 1'b1, 64'h8040_2010_0804_0201, 64'h0102_0408_1020_4080);

        // random settings, each followed by a batch of random rows
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            gaps_on <= (phase % 3 != 2);
            for (k = 0; k < 4; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    wgt[k] = $urandom_range(0, 1) ? 8'h7f : 8'h80;
                end else begin
                    wgt[k] = WEIGHT_W'($urandom_range(0, 255));
                end
            end
            shift = $urandom_range(0, 8);
            case ($urandom_range(0, 3))
                0:       rnd = 0;
                1:       rnd = 256;
                2:       rnd = $urandom_range(0, 256);
                default: rnd = (shift > 0) ? (1 << (shift - 1)) : 0;
            endcase
            ofs_m = OFFSET_W'($urandom_range(0, 255));
            ofs_a = OFFSET_W'($urandom_range(0, 255));
            set_config(wgt[0], wgt[1], wgt[2], wgt[3], ROUND_W'(rnd), SHIFT_W'(shift),
                       ofs_m, ofs_a);
            for (n = 0; n < ROWS_PER_PHASE; n++) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    act = ACT_AVG;
                end else if (r < 60) begin
                    act = ACT_SINGLE;
                end else if (r < 97) begin
                    act = ACT_BI;
                end else begin
                    act = ACT_RESERVED;
                end
                send_row(act, 1'($urandom_range(0, 1)), pixel_row(), pixel_row());
            end
        end

        drain_rows();
        $display("rows sent: %0d (average %0d, single %0d, bi %0d, unused code %0d), %0d interleaved",
                 rows_sent, action_rows[ACT_AVG], action_rows[ACT_SINGLE],
                 action_rows[ACT_BI], action_rows[ACT_RESERVED], inter_rows);
        $display("%0d predicted rows compared over %0d register settings plus the reset one",
                 checked, settings_applied);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d failures, %0d predicted rows never came out", errors, pending);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/wpp_pkg.sv
sv/wpp_in_if.sv
sv/wpp_out_if.sv
sv/weighted_pixel_prediction.sv
sv/wpp_checker.sv
tb/sv/wpp_row_checker.sv
tb/sv/tb_weighted_pixel_prediction.sv
